@@ hdl/mwsm_pkg.sv @@
// shared types, constants and the arctangent table of the wheel speed mixer
package mwsm_pkg;

    localparam int MAX_STAGES = 24;
    localparam int XW = 32;
    localparam int ZW = 28;
    localparam int TW = 27;

    localparam logic signed [XW-1:0] CORDIC_X0 = 32'sd652032874;
    localparam logic signed [13:0] OUT_MAX = 14'sd8191;
    localparam logic signed [13:0] OUT_MIN = {1'b1, 13'b0};

    typedef enum logic [2:0] {
        REG_ROTATION_ENABLE = 3'd0,
        REG_DEADBAND        = 3'd1,
        REG_TURN_GAIN       = 3'd2,
        REG_HALF_LENGTH     = 3'd3,
        REG_SPEED_LIMIT     = 3'd4,
        REG_FALLBACK_SPEED  = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        QUAD_FRONT = 2'd0,
        QUAD_RIGHT = 2'd1,
        QUAD_BACK  = 2'd2,
        QUAD_LEFT  = 2'd3
    } quad_t;

    typedef struct packed {
        logic        rot;
        logic [10:0] deadband;
        logic [7:0]  gain;
        logic [5:0]  half_len;
        logic [12:0] limit;
        logic [11:0] fallback;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        rot:      1'b1,
        deadband: 11'd150,
        gain:     8'd102,
        half_len: 6'd14,
        limit:    13'd3500,
        fallback: 12'd2000
    };

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } vec_t;

    typedef struct packed {
        quad_t                quad;
        logic [11:0]          spd;
        logic signed [TW-1:0] tnum;
        logic                 limited;
    } side_t;

    typedef struct packed {
        logic signed [13:0] fl;
        logic signed [13:0] fr;
        logic signed [13:0] bl;
        logic signed [13:0] br;
        logic               limited;
    } result_t;

    // atan(2^-i) in degrees, q.20
    function automatic logic signed [ZW-1:0] atan_q20(input int i);
        logic signed [ZW-1:0] a;
        unique case (i)
            0:  a = 28'sd47185920;
            1:  a = 28'sd27855475;
            2:  a = 28'sd14718068;
            3:  a = 28'sd7471121;
            4:  a = 28'sd3750058;
            5:  a = 28'sd1876857;
            6:  a = 28'sd938658;
            7:  a = 28'sd469357;
            8:  a = 28'sd234682;
            9:  a = 28'sd117342;
            10: a = 28'sd58671;
            11: a = 28'sd29335;
            12: a = 28'sd14668;
            13: a = 28'sd7334;
            14: a = 28'sd3667;
            15: a = 28'sd1833;
            16: a = 28'sd917;
            17: a = 28'sd458;
            18: a = 28'sd229;
            19: a = 28'sd115;
            20: a = 28'sd57;
            21: a = 28'sd29;
            22: a = 28'sd14;
            23: a = 28'sd7;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ hdl/mwsm_front.sv @@
// front pipeline: heading fold, cordic angle, turn term and speed limit check
module mwsm_front
    import mwsm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  logic [11:0]          up_heading,
    input  logic [11:0]          up_speed,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output logic signed [ZW-1:0] dn_z,
    output side_t                dn_side
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1 registers
    quad_t              s1_quad_reg, s1_quad_next;
    logic               s1_rneg_reg, s1_rneg_next;
    logic [8:0]         s1_mag_reg, s1_mag_next;
    logic signed [11:0] s1_wt_reg, s1_wt_next;
    logic [11:0]        s1_spd_reg;

    // stage 2 registers
    quad_t              s2_quad_reg;
    logic               s2_rneg_reg;
    logic [25:0]        s2_zmag_reg, s2_zmag_next;
    logic signed [20:0] s2_gw_reg, s2_gw_next;
    logic [11:0]        s2_spd_reg;

    // stage 3 registers
    quad_t                s3_quad_reg;
    logic signed [ZW-1:0] s3_z_reg, s3_z_next;
    logic signed [TW-1:0] s3_tnum_reg, s3_tnum_next;
    logic [11:0]          s3_spd_reg;

    // stage 4 registers
    logic signed [ZW-1:0] s4_z_reg;
    side_t                s4_side_reg, s4_side_next;

    logic [11:0]        hc;
    logic [11:0]        base;
    logic signed [12:0] r;
    logic signed [12:0] w;
    logic [10:0]        aw;
    logic [11:0]        f2_t;
    logic [24:0]        f2_p;
    logic [25:0]        f2_a;
    logic signed [33:0] f4_t, f4_s, f4_lhs, f4_rhs;
    logic               trip;

    assign rdy4     = !v4_reg || dn_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign up_ready = rdy1;
    assign dn_valid = v4_reg;
    assign dn_z     = s4_z_reg;
    assign dn_side  = s4_side_reg;

    // fold to nearest quarter turn and to a signed turn angle
    always_comb
    begin
        hc = (up_heading > 12'd3600) ? 12'd3600 : up_heading;
        priority if (hc < 12'd450)
        begin
            s1_quad_next = QUAD_FRONT;
            base         = 12'd0;
        end
        else if (hc < 12'd1350)
        begin
            s1_quad_next = QUAD_RIGHT;
            base         = 12'd900;
        end
        else if (hc < 12'd2250)
        begin
            s1_quad_next = QUAD_BACK;
            base         = 12'd1800;
        end
        else if (hc < 12'd3150)
        begin
            s1_quad_next = QUAD_LEFT;
            base         = 12'd2700;
        end
        else
        begin
            s1_quad_next = QUAD_FRONT;
            base         = 12'd3600;
        end
        r            = $signed({1'b0, hc}) - $signed({1'b0, base});
        s1_rneg_next = r[12];
        s1_mag_next  = r[12] ? 9'(-r) : 9'(r);
        w            = (hc <= 12'd1800) ? $signed({1'b0, hc})
                                        : $signed({1'b0, hc}) - 13'sd3600;
        aw           = w[12] ? 11'(-w) : 11'(w);
        s1_wt_next   = (cfg.rot && aw >= cfg.deadband) ? 12'(w) : '0;
    end

    // angle * 2^20 / 10 rounded, split as mag*104857 + (6*mag + 5) / 10
    always_comb
    begin
        f2_t         = 12'(s1_mag_reg) * 12'd6 + 12'd5;
        f2_p         = 25'(f2_t) * 25'd6554;
        f2_a         = 26'(s1_mag_reg) * 26'd104857;
        s2_zmag_next = f2_a + 26'(f2_p[24:16]);
        s2_gw_next   = 21'($signed({1'b0, cfg.gain})) * 21'(s1_wt_reg);
    end

    always_comb
    begin
        s3_z_next    = s2_rneg_reg ? -$signed({2'b0, s2_zmag_reg})
                                   : $signed({2'b0, s2_zmag_reg});
        s3_tnum_next = TW'(s2_gw_reg) * TW'($signed({1'b0, cfg.half_len}));
    end

    // exact limit check: 25*t + 90496*s > 64000*limit
    always_comb
    begin
        f4_t   = 34'(s3_tnum_reg) * 34'sd25;
        f4_s   = $signed(34'(s3_spd_reg)) * 34'sd90496;
        f4_rhs = $signed(34'(cfg.limit)) * 34'sd64000;
        f4_lhs = f4_t + f4_s;
        trip   = cfg.rot && (f4_lhs > f4_rhs);
        s4_side_next.quad    = s3_quad_reg;
        s4_side_next.spd     = trip ? cfg.fallback : s3_spd_reg;
        s4_side_next.tnum    = s3_tnum_reg;
        s4_side_next.limited = trip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= up_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && up_valid)
        begin
            s1_quad_reg <= s1_quad_next;
            s1_rneg_reg <= s1_rneg_next;
            s1_mag_reg  <= s1_mag_next;
            s1_wt_reg   <= s1_wt_next;
            s1_spd_reg  <= up_speed;
        end
        if (rdy2 && v1_reg)
        begin
            s2_quad_reg <= s1_quad_reg;
            s2_rneg_reg <= s1_rneg_reg;
            s2_zmag_reg <= s2_zmag_next;
            s2_gw_reg   <= s2_gw_next;
            s2_spd_reg  <= s1_spd_reg;
        end
        if (rdy3 && v2_reg)
        begin
            s3_quad_reg <= s2_quad_reg;
            s3_z_reg    <= s3_z_next;
            s3_tnum_reg <= s3_tnum_next;
            s3_spd_reg  <= s2_spd_reg;
        end
        if (rdy4 && v3_reg)
        begin
            s4_z_reg    <= s3_z_reg;
            s4_side_reg <= s4_side_next;
        end
    end

endmodule

@@ hdl/mwsm_cordic_cell.sv @@
// one cordic rotation step with its own pipeline register
module mwsm_cordic_cell
    import mwsm_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    output logic  up_ready,
    input  vec_t  up_vec,
    input  side_t up_side,
    output logic  dn_valid,
    input  logic  dn_ready,
    output vec_t  dn_vec,
    output side_t dn_side
);

    logic                 valid_reg;
    vec_t                 vec_reg, vec_next;
    side_t                side_reg;
    logic signed [XW-1:0] x_in, y_in, dx, dy;
    logic signed [ZW-1:0] z_in, da;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_vec   = vec_reg;
    assign dn_side  = side_reg;

    assign x_in = up_vec.x;
    assign y_in = up_vec.y;
    assign z_in = up_vec.z;
    assign dx   = y_in >>> STAGE;
    assign dy   = x_in >>> STAGE;
    assign da   = atan_q20(STAGE);

    always_comb
    begin
        if (!z_in[ZW-1])
        begin
            vec_next.x = x_in - dx;
            vec_next.y = y_in + dy;
            vec_next.z = z_in - da;
        end
        else
        begin
            vec_next.x = x_in + dx;
            vec_next.y = y_in - dy;
            vec_next.z = z_in + da;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            vec_reg  <= vec_next;
            side_reg <= up_side;
        end
    end

endmodule

@@ hdl/mwsm_back.sv @@
// back pipeline: q1.15 rounding, quadrant rotation, wheel products and output register
module mwsm_back
    import mwsm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    up_valid,
    output logic    up_ready,
    input  vec_t    up_vec,
    input  side_t   up_side,
    output logic    dn_valid,
    input  logic    dn_ready,
    output result_t dn_result
);

    typedef struct packed {
        logic        neg;
        logic [17:0] q0;
    } wdiv_t;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic signed [15:0]    c1_reg, c1_next, s1_reg, s1_next;
    side_t                 side1_reg;
    logic signed [29:0]    psum2_reg, psum2_next, pdiff2_reg, pdiff2_next;
    logic signed [TW-1:0]  tnum2_reg;
    logic                  lim2_reg;
    wdiv_t                 fl3_reg, fl3_next, fr3_reg, fr3_next;
    wdiv_t                 bl3_reg, bl3_next, br3_reg, br3_next;
    logic                  lim3_reg;
    result_t               res4_reg, res4_next;

    logic signed [15:0] c0, s0;
    logic signed [16:0] sum, diff;
    logic signed [33:0] psum5, pdiff5, t64;

    // round to q1.15 half away from zero, saturate to +-32767
    function automatic logic signed [15:0] round_q15(input logic signed [XW-1:0] v);
        logic [XW-1:0]   mag;
        logic [XW:0]     acc;
        logic [XW-15:0]  q;
        logic [14:0]     lim;
        mag = v[XW-1] ? XW'(-v) : XW'(v);
        acc = (XW+1)'(mag) + (XW+1)'(16384);
        q   = acc[XW:15];
        lim = (q > (XW-14)'(32767)) ? 15'd32767 : q[14:0];
        return v[XW-1] ? -$signed({1'b0, lim}) : $signed({1'b0, lim});
    endfunction

    // magnitude + half divisor, already divided by 2^15
    function automatic wdiv_t wheel_div(input logic signed [33:0] num);
        logic [33:0] mag;
        logic [33:0] acc;
        wdiv_t       d;
        mag   = num[33] ? 34'(-num) : 34'(num);
        acc   = mag + 34'd81920;
        d.neg = num[33];
        d.q0  = acc[32:15];
        return d;
    endfunction

    // remaining divide by 5 via reciprocal, then saturate
    function automatic logic signed [13:0] wheel_sat(input wdiv_t d);
        logic [33:0]        prod;
        logic [15:0]        rr;
        logic signed [13:0] o;
        prod = 34'(d.q0) * 34'd52429;
        rr   = prod[33:18];
        if (d.neg)
            o = (rr > 16'd8192) ? OUT_MIN : 14'(-$signed({1'b0, rr}));
        else
            o = (rr > 16'd8191) ? OUT_MAX : $signed(14'(rr));
        return o;
    endfunction

    assign rdy4      = !v4_reg || dn_ready;
    assign rdy3      = !v3_reg || rdy4;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign up_ready  = rdy1;
    assign dn_valid  = v4_reg;
    assign dn_result = res4_reg;

    always_comb
    begin
        c0 = round_q15(up_vec.x);
        s0 = round_q15(up_vec.y);
        unique case (up_side.quad)
            QUAD_FRONT:
            begin
                c1_next = c0;
                s1_next = s0;
            end
            QUAD_RIGHT:
            begin
                c1_next = -s0;
                s1_next = c0;
            end
            QUAD_BACK:
            begin
                c1_next = -c0;
                s1_next = -s0;
            end
            QUAD_LEFT:
            begin
                c1_next = s0;
                s1_next = -c0;
            end
            default:
            begin
                c1_next = c0;
                s1_next = s0;
            end
        endcase
    end

    always_comb
    begin
        sum         = 17'(c1_reg) + 17'(s1_reg);
        diff        = 17'(c1_reg) - 17'(s1_reg);
        psum2_next  = 30'($signed({1'b0, side1_reg.spd})) * 30'(sum);
        pdiff2_next = 30'($signed({1'b0, side1_reg.spd})) * 30'(diff);
    end

    always_comb
    begin
        psum5    = 34'(psum2_reg) * 34'sd5;
        pdiff5   = 34'(pdiff2_reg) * 34'sd5;
        t64      = 34'(tnum2_reg) <<< 6;
        fl3_next = wheel_div(psum5 - t64);
        fr3_next = wheel_div(pdiff5 + t64);
        bl3_next = wheel_div(pdiff5 - t64);
        br3_next = wheel_div(psum5 + t64);
    end

    always_comb
    begin
        res4_next.fl      = wheel_sat(fl3_reg);
        res4_next.fr      = wheel_sat(fr3_reg);
        res4_next.bl      = wheel_sat(bl3_reg);
        res4_next.br      = wheel_sat(br3_reg);
        res4_next.limited = lim3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= up_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && up_valid)
        begin
            c1_reg    <= c1_next;
            s1_reg    <= s1_next;
            side1_reg <= up_side;
        end
        if (rdy2 && v1_reg)
        begin
            psum2_reg  <= psum2_next;
            pdiff2_reg <= pdiff2_next;
            tnum2_reg  <= side1_reg.tnum;
            lim2_reg   <= side1_reg.limited;
        end
        if (rdy3 && v2_reg)
        begin
            fl3_reg  <= fl3_next;
            fr3_reg  <= fr3_next;
            bl3_reg  <= bl3_next;
            br3_reg  <= br3_next;
            lim3_reg <= lim2_reg;
        end
        if (rdy4 && v3_reg)
            res4_reg <= res4_next;
    end

endmodule

@@ hdl/mecanum_wheel_speed_mixer.sv @@
// top level of the mecanum wheel speed mixer: config registers and pipeline chain
//
//   channel   direction   handshake                  payload
//   s_axis    in          s_axis_tvalid/tready       heading_tenths, drive_speed
//   m_axis    out         m_axis_tvalid/tready       four wheel speeds, speed_limited
//   cfg       in          cfg_valid/cfg_ready        cfg_index, cfg_data
//
// one command per cycle while the output is not stalled; the chain holds 4 front stages,
// one cordic cell per sine stage, capped at 24 cordic cells, and 4 back stages.
// every stage has its own valid bit and moves when the next one is free, so
// a stalled output only blocks once the whole chain is full.
// reset clears the valid bits and loads the default register values.
// cfg_ready is always high; a write to an unknown index is dropped.
module mecanum_wheel_speed_mixer
    import mwsm_pkg::*;
#(
    parameter int SINE_STAGES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // heading_tenths[11:0], drive_speed[23:12]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // front_left[13:0], front_right[27:14],
                                        // back_left[41:28], back_right[55:42]
    output logic [0:0]  m_axis_tuser,   // speed_limited[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int NCELL = (SINE_STAGES > MAX_STAGES) ? MAX_STAGES : SINE_STAGES;

    cfg_t cfg_reg, cfg_next;

    logic                 front_valid;
    logic signed [ZW-1:0] front_z;
    side_t                front_side;

    logic  chain_valid [NCELL+1];
    logic  chain_ready [NCELL+1];
    vec_t  chain_vec   [NCELL+1];
    side_t chain_side  [NCELL+1];

    result_t result;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_ROTATION_ENABLE: cfg_next.rot      = cfg_data[0];
                REG_DEADBAND:        cfg_next.deadband = cfg_data[10:0];
                REG_TURN_GAIN:       cfg_next.gain     = cfg_data[7:0];
                REG_HALF_LENGTH:     cfg_next.half_len = cfg_data[5:0];
                REG_SPEED_LIMIT:     cfg_next.limit    = cfg_data[12:0];
                REG_FALLBACK_SPEED:  cfg_next.fallback = cfg_data[11:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    mwsm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .up_valid   (s_axis_tvalid),
        .up_ready   (s_axis_tready),
        .up_heading (s_axis_tdata[11:0]),
        .up_speed   (s_axis_tdata[23:12]),
        .dn_valid   (front_valid),
        .dn_ready   (chain_ready[0]),
        .dn_z       (front_z),
        .dn_side    (front_side)
    );

    // cordic starts from the gain-compensated unit vector
    assign chain_valid[0]  = front_valid;
    assign chain_vec[0].x  = CORDIC_X0;
    assign chain_vec[0].y  = '0;
    assign chain_vec[0].z  = front_z;
    assign chain_side[0]   = front_side;

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        mwsm_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[g]),
            .up_ready (chain_ready[g]),
            .up_vec   (chain_vec[g]),
            .up_side  (chain_side[g]),
            .dn_valid (chain_valid[g+1]),
            .dn_ready (chain_ready[g+1]),
            .dn_vec   (chain_vec[g+1]),
            .dn_side  (chain_side[g+1])
        );
    end

    mwsm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (chain_valid[NCELL]),
        .up_ready  (chain_ready[NCELL]),
        .up_vec    (chain_vec[NCELL]),
        .up_side   (chain_side[NCELL]),
        .dn_valid  (m_axis_tvalid),
        .dn_ready  (m_axis_tready),
        .dn_result (result)
    );

    assign m_axis_tdata = {result.br, result.bl, result.fr, result.fl};
    assign m_axis_tuser = result.limited;

endmodule
